>>> src/spq_pkg.sv
// Sorted priority queue package: sizes, entry and cell control types, codes.
// Used by spq_cell and sorted_priority_queue; depends on nothing.
package spq_pkg;

	localparam int QUEUE_DEPTH    = 16;
	localparam int VALUE_WIDTH    = 32;
	localparam int PRIORITY_WIDTH = 8;
	localparam int MAX_POP        = 16;

	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W = $clog2(MAX_POP + 1);
	localparam int CMP_W = (OCC_W > CNT_W) ? OCC_W : CNT_W;

	typedef enum logic {
		REQ_ENQ = 1'b0,
		REQ_DEQ = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2
	} op_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0]    val;
		logic [PRIORITY_WIDTH-1:0] pri;
	} entry_t;

	typedef struct packed {
		op_t    op;
		entry_t data;
	} cell_ctl_t;

endpackage

>>> src/spq_cell.sv
// One cell of the sorted shifting array: holds one entry, compares, shifts.
// Depends on spq_pkg.
module spq_cell (
	input  logic               clk,
	input  spq_pkg::cell_ctl_t ctl,
	input  logic               valid,
	input  logic               left_le,
	input  spq_pkg::entry_t    left_d,
	input  spq_pkg::entry_t    right_d,
	output logic               le,
	output spq_pkg::entry_t    d
);
	import spq_pkg::*;

	entry_t d_q;

	assign le = valid && (d_q.pri <= ctl.data.pri);
	assign d  = d_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (!le) begin
					if (left_le) begin
						d_q <= ctl.data;
					end else begin
						d_q <= left_d;
					end
				end
			end
			OP_POP: begin
				d_q <= right_d;
			end
			default: begin
				d_q <= d_q;
			end
		endcase
	end

endmodule

>>> src/sorted_priority_queue.sv
// Sorted priority queue top level: a row of spq_cell entries plus control.
// Enqueue and empty/zero-count dequeue: one result, visible the cycle after transfer;
// one such request per cycle if the output is free. Dequeue of N: state enters ST_POP,
// then each pop loads value_q, one per cycle if the output is free; no input is
// taken until done; one cell shift per pop sets the pace. Reset (arst_n, asynchronous)
// empties the queue; cell contents are not cleared. Depends on spq_pkg and spq_cell.
module sorted_priority_queue (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               req_type,
	input  logic [spq_pkg::VALUE_WIDTH-1:0]    value_in,
	input  logic [spq_pkg::PRIORITY_WIDTH-1:0] priority_in,
	input  logic [4:0]                         pop_count,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [spq_pkg::VALUE_WIDTH-1:0]    value_out,
	output logic [1:0]                         status,
	output logic                               last,
	output logic [4:0]                         popped_total
);
	import spq_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} state_t;

	state_t                  state_q;
	logic [OCC_W-1:0]        occ_q;
	logic [CNT_W-1:0]        rem_q;
	logic [CNT_W-1:0]        done_q;
	logic                    out_valid_q;
	logic [VALUE_WIDTH-1:0]  value_q;
	logic [1:0]              status_q;
	logic                    last_q;
	logic [4:0]              total_q;

	logic                    out_free;
	logic                    in_fire;
	logic                    pop_fire;
	logic                    out_load;
	logic                    full;
	logic [CNT_W-1:0]        want;
	logic [CNT_W-1:0]        n_pop;
	cell_ctl_t               ctl;
	entry_t                  cell_d  [QUEUE_DEPTH];
	logic                    cell_le [QUEUE_DEPTH];

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && out_free;
	assign in_fire  = in_valid && in_ready;
	assign pop_fire = (state_q == ST_POP) && out_free;
	assign full     = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign out_load = pop_fire ||
		(in_fire && ((req_type == REQ_ENQ) || (occ_q == '0) || (want == '0)));

	always_comb begin
		if (32'(pop_count) > 32'(MAX_POP)) begin
			want = CNT_W'(MAX_POP);
		end else begin
			want = CNT_W'(pop_count);
		end
		if (CMP_W'(want) < CMP_W'(occ_q)) begin
			n_pop = want;
		end else begin
			n_pop = CNT_W'(occ_q);
		end
	end

	always_comb begin
		ctl.data.val = value_in;
		ctl.data.pri = priority_in;
		if (in_fire && (req_type == REQ_ENQ) && !full) begin
			ctl.op = OP_INSERT;
		end else if (pop_fire) begin
			ctl.op = OP_POP;
		end else begin
			ctl.op = OP_HOLD;
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_le;
		entry_t left_d;
		entry_t right_d;
		if (i == 0) begin : g_head
			assign left_le = 1'b1;
			assign left_d  = ctl.data;
		end else begin : g_body
			assign left_le = cell_le[i-1];
			assign left_d  = cell_d[i-1];
		end
		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_d = cell_d[i];
		end else begin : g_inner
			assign right_d = cell_d[i+1];
		end
		spq_cell u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.valid   (OCC_W'(i) < occ_q),
			.left_le (left_le),
			.left_d  (left_d),
			.right_d (right_d),
			.le      (cell_le[i]),
			.d       (cell_d[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			occ_q       <= '0;
			rem_q       <= '0;
			done_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_fire) begin
				if (req_type == REQ_ENQ) begin
					if (!full) begin
						occ_q <= occ_q + 1'b1;
					end
				end else if ((occ_q != '0) && (want != '0)) begin
					state_q <= ST_POP;
					rem_q   <= n_pop;
					done_q  <= '0;
				end
			end
			if (pop_fire) begin
				occ_q       <= occ_q - 1'b1;
				rem_q       <= rem_q - 1'b1;
				done_q      <= done_q + 1'b1;
				if (rem_q == CNT_W'(1)) begin
					state_q <= ST_IDLE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			value_q <= '0;
			last_q  <= 1'b1;
			total_q <= '0;
			if (req_type == REQ_ENQ) begin
				status_q <= full ? STAT_FULL : STAT_OK;
			end else if (occ_q == '0) begin
				status_q <= STAT_EMPTY;
			end else begin
				status_q <= STAT_OK;
			end
		end else if (pop_fire) begin
			value_q  <= cell_d[0].val;
			status_q <= STAT_OK;
			last_q   <= (rem_q == CNT_W'(1));
			total_q  <= (rem_q == CNT_W'(1)) ? (5'(done_q) + 5'd1) : 5'd0;
		end
	end

	assign out_valid    = out_valid_q;
	assign value_out    = value_q;
	assign status       = status_q;
	assign last         = last_q;
	assign popped_total = total_q;

`ifndef ASSERT_OFF
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy above queue depth");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |-> occ_q != '0)
		else $error("pop from empty queue");

	a_pop_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> rem_q != '0)
		else $error("pop state with nothing left to pop");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (req_type == REQ_ENQ) && full) |=> $stable(occ_q))
		else $error("rejected enqueue changed occupancy");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		pop_fire |=> occ_q == $past(occ_q) - 1'b1)
		else $error("pop did not remove exactly one entry");
`endif

endmodule
